// ===== rtl/core/shli_pkg.sv =====
// Shared constants and types for the sorted hit list insert unit.
package shli_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        obj;
    logic [2:0]         kind;
  } hit_entry_t;

  typedef struct packed {
    logic insert;
    logic drain_shift;
  } chain_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

endpackage

// ===== rtl/core/shli_cell.sv =====
// One cell of the sorted hit chain: holds one entry and trades it with its neighbors.
module shli_cell
  import shli_pkg::*;
(
  input  logic       clk_i,
  input  chain_ctl_t ctl_i,
  input  logic       occupied_i,
  input  logic       left_gt_i,
  input  hit_entry_t left_i,
  input  hit_entry_t right_i,
  input  hit_entry_t new_i,
  output logic       gt_o,
  output hit_entry_t entry_o
);

  hit_entry_t entry_q;
  hit_entry_t entry_d;

  assign gt_o    = occupied_i && (entry_q.key > new_i.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else if (gt_o || !occupied_i) begin
        entry_d = new_i;
      end
    end else if (ctl_i.drain_shift) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/core/shli_chain.sv =====
// Row of sorted hit cells with the slot encoder for an insert.
module shli_chain
  import shli_pkg::*;
(
  input  logic             clk_i,
  input  chain_ctl_t       ctl_i,
  input  logic [CNT_W-1:0] count_i,
  input  hit_entry_t       new_i,
  output logic [CNT_W-1:0] slot_o,
  output hit_entry_t       head_o
);

  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] occupied;
  hit_entry_t          entries [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       left_gt;
    hit_entry_t left_entry;
    hit_entry_t right_entry;

    assign occupied[i] = CNT_W'(i) < count_i;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = new_i;
    end else begin : g_inner
      assign left_gt    = gt[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    shli_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl_i),
      .occupied_i(occupied[i]),
      .left_gt_i (left_gt),
      .left_i    (left_entry),
      .right_i   (right_entry),
      .new_i     (new_i),
      .gt_o      (gt[i]),
      .entry_o   (entries[i])
    );
  end

  always_comb begin
    logic [CNT_W-1:0] slot_or;
    slot_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i-1])) begin
        slot_or = slot_or | CNT_W'(i);
      end
    end
    slot_o = (|gt) ? slot_or : count_i;
  end

  assign head_o = entries[0];

endmodule

// ===== rtl/core/sorted_hit_list_insert_unit.sv =====
// Top level of the sorted hit list insert unit.
// Keeps up to CAPACITY ray hits sorted by ascending signed Q16.16 distance in a chain of
// cells that all compare against a new hit at once. An insert yields one result
// transaction with the slot used and the new count; an insert into a full list is
// dropped and flagged as overflow. A drain shifts the chain toward its head one entry per
// cycle while the output is not stalled, yields one transaction per held entry, the final
// one marked last, then leaves the list empty; a drain of an empty list yields one invalid
// transaction. No input is taken until a drain ends.
// Results wait in an output register, so a new input is taken while the last result is
// being handed off.
module sorted_hit_list_insert_unit
  import shli_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [31:0] hit_distance_i,
  input  logic [15:0]        object_id_i,
  input  logic [2:0]         object_kind_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         inserted_at_o,
  output logic [4:0]         entry_count_o,
  output logic               overflow_o,
  output logic               entry_valid_o,
  output logic signed [31:0] entry_distance_o,
  output logic [15:0]        entry_object_o,
  output logic [2:0]         entry_kind_o,
  output logic               last_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  logic [4:0]       out_at_q, out_at_d;
  logic [4:0]       out_count_q, out_count_d;
  logic             out_ovf_q, out_ovf_d;
  hit_entry_t       out_entry_q, out_entry_d;
  logic             out_entry_valid_q, out_entry_valid_d;
  logic             out_last_q, out_last_d;

  logic             out_free;
  logic             in_acc;
  chain_ctl_t       ctl;
  hit_entry_t       new_entry;
  hit_entry_t       head;
  logic [CNT_W-1:0] slot;

  assign new_entry = '{key: hit_distance_i, obj: object_id_i, kind: object_kind_i};

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  shli_chain u_chain (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .count_i(count_q),
    .new_i  (new_entry),
    .slot_o (slot),
    .head_o (head)
  );

  always_comb begin
    state_d           = state_q;
    count_d           = count_q;
    rem_d             = rem_q;
    ctl               = '0;
    out_valid_d       = out_valid_q && out_stall_i;
    out_at_d          = out_at_q;
    out_count_d       = out_count_q;
    out_ovf_d         = out_ovf_q;
    out_entry_d       = out_entry_q;
    out_entry_valid_d = out_entry_valid_q;
    out_last_d        = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_d       = 1'b1;
          out_at_d          = '0;
          out_ovf_d         = 1'b0;
          out_entry_d       = '0;
          out_entry_valid_d = 1'b0;
          out_last_d        = 1'b1;
          out_count_d       = '0;
          if (kind_i == KIND_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              out_ovf_d   = 1'b1;
              out_count_d = 5'(count_q);
            end else begin
              ctl.insert  = 1'b1;
              count_d     = count_q + CNT_W'(1);
              out_at_d    = 5'(slot);
              out_count_d = 5'(count_d);
            end
          end else begin
            count_d = '0;
            if (count_q != '0) begin
              out_valid_d = 1'b0;
              rem_d       = count_q;
              state_d     = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          ctl.drain_shift   = 1'b1;
          out_valid_d       = 1'b1;
          out_at_d          = '0;
          out_count_d       = '0;
          out_ovf_d         = 1'b0;
          out_entry_d       = head;
          out_entry_valid_d = 1'b1;
          out_last_d        = (rem_q == CNT_W'(1));
          rem_d             = rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_at_q          <= out_at_d;
    out_count_q       <= out_count_d;
    out_ovf_q         <= out_ovf_d;
    out_entry_q       <= out_entry_d;
    out_entry_valid_q <= out_entry_valid_d;
    out_last_q        <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign inserted_at_o    = out_at_q;
  assign entry_count_o    = out_count_q;
  assign overflow_o       = out_ovf_q;
  assign entry_valid_o    = out_entry_valid_q;
  assign entry_distance_o = out_entry_q.key;
  assign entry_object_o   = out_entry_q.obj;
  assign entry_kind_o     = out_entry_q.kind;
  assign last_o           = out_last_q;

endmodule
